// ===== hdl/hsfc_pkg.sv =====
package hsfc_pkg;

  localparam logic MODE_S2H = 1'b0;
  localparam logic MODE_H2S = 1'b1;

  localparam logic [7:0] EXP8_ALL_ONES = 8'hFF;
  localparam logic [4:0] EXP5_ALL_ONES = 5'h1F;
  localparam logic [7:0] BIAS_DIFF     = 8'd112;
  localparam logic [7:0] SUB_EXP_BASE  = 8'd113;
  localparam logic [7:0] S2H_OVF_EXP   = 8'd143;
  localparam logic [9:0] HALF_QNAN_BIT = 10'h200;
  localparam int unsigned MANT10_W     = 10;

  typedef struct packed {
    logic special;
    logic zero;
    logic over;
    logic sub;
  } cls_t;

  typedef struct packed {
    logic       mode;
    logic       sign;
    logic [7:0] exp;
    logic [9:0] mant;
    logic       mant_nz;
    cls_t       cls;
  } s1_t;

  typedef struct packed {
    logic       mode;
    logic       sign;
    logic [7:0] exp;
    logic [9:0] mant;
  } s2_t;

endpackage

// ===== hdl/half_single_float_converter.sv =====
// half/single precision converter, one word in and one word out per item
// input channel: in_valid, in_mode, in_value_in; in_stall pushes back
//   in_mode 0: in_value_in holds single bits, result is half bits in the low 16
//   in_mode 1: low 16 bits of in_value_in hold half bits, result is single bits
// output channel: out_valid, out_value_out; the receiver drives out_stall
// single to half truncates the mantissa, flushes small values to signed zero
//   and saturates large values to signed infinity; nan keeps a quiet bit
// half to single is exact, subnormals are normalized
// throughput: one word per cycle while out_stall is low, set by the three
//   register stages (decode, exponent and normalize, assemble), each taking
//   one word a cycle
// out_stall holds the output word; earlier stages keep filling until all
//   three hold a word, only then in_stall rises
// reset clears the stage valid bits, the block is empty and ready afterward
module half_single_float_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [31:0] in_value_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value_out
);

  logic v1_r, v1_nxt;
  logic v2_r, v2_nxt;
  logic v3_r, v3_nxt;
  logic en1, en2, en3;

  hsfc_pkg::s1_t s1_r, s1_nxt;
  hsfc_pkg::s2_t s2_r, s2_nxt;
  logic [31:0]   out_r, out_nxt;

  logic [3:0] lz;
  logic [9:0] mant_sh;

  assign en3 = !out_stall || !v3_r;
  assign en2 = en3 || !v2_r;
  assign en1 = en2 || !v1_r;

  assign in_stall      = !en1;
  assign out_valid     = v3_r;
  assign out_value_out = out_r;

  assign v1_nxt = en1 ? in_valid : v1_r;
  assign v2_nxt = en2 ? v1_r : v2_r;
  assign v3_nxt = en3 ? v2_r : v3_r;

  // decode and classify
  always_comb begin
    s1_nxt      = '0;
    s1_nxt.mode = in_mode;
    if (in_mode == hsfc_pkg::MODE_S2H) begin
      s1_nxt.sign        = in_value_in[31];
      s1_nxt.exp         = in_value_in[30:23];
      s1_nxt.mant        = in_value_in[22:13];
      s1_nxt.mant_nz     = |in_value_in[22:0];
      s1_nxt.cls.special = in_value_in[30:23] == hsfc_pkg::EXP8_ALL_ONES;
      s1_nxt.cls.zero    = in_value_in[30:23] <= hsfc_pkg::BIAS_DIFF;
      s1_nxt.cls.over    = in_value_in[30:23] >= hsfc_pkg::S2H_OVF_EXP;
      s1_nxt.cls.sub     = 1'b0;
    end else begin
      s1_nxt.sign        = in_value_in[15];
      s1_nxt.exp         = {3'b000, in_value_in[14:10]};
      s1_nxt.mant        = in_value_in[9:0];
      s1_nxt.mant_nz     = |in_value_in[9:0];
      s1_nxt.cls.special = in_value_in[14:10] == hsfc_pkg::EXP5_ALL_ONES;
      s1_nxt.cls.zero    = (in_value_in[14:10] == 5'd0) && !(|in_value_in[9:0]);
      s1_nxt.cls.over    = 1'b0;
      s1_nxt.cls.sub     = (in_value_in[14:10] == 5'd0) && (|in_value_in[9:0]);
    end
  end

  // shift for half subnormals, one more than the leading zero count, highest set bit wins
  always_comb begin
    lz = 4'd0;
    for (int i = 0; i < hsfc_pkg::MANT10_W; i++) begin
      if (s1_r.mant[i]) begin
        lz = 4'(hsfc_pkg::MANT10_W - i);
      end
    end
    mant_sh = s1_r.mant << lz;
  end

  // exponent and mantissa of the result
  always_comb begin
    s2_nxt.mode = s1_r.mode;
    s2_nxt.sign = s1_r.sign;
    s2_nxt.exp  = '0;
    s2_nxt.mant = '0;
    if (s1_r.mode == hsfc_pkg::MODE_S2H) begin
      if (s1_r.cls.special) begin
        s2_nxt.exp  = {3'b000, hsfc_pkg::EXP5_ALL_ONES};
        s2_nxt.mant = s1_r.mant_nz ? hsfc_pkg::HALF_QNAN_BIT : 10'd0;
      end else if (s1_r.cls.zero) begin
        s2_nxt.exp  = 8'd0;
        s2_nxt.mant = 10'd0;
      end else if (s1_r.cls.over) begin
        s2_nxt.exp  = {3'b000, hsfc_pkg::EXP5_ALL_ONES};
        s2_nxt.mant = 10'd0;
      end else begin
        s2_nxt.exp  = s1_r.exp - hsfc_pkg::BIAS_DIFF;
        s2_nxt.mant = s1_r.mant;
      end
    end else begin
      if (s1_r.cls.special) begin
        s2_nxt.exp  = hsfc_pkg::EXP8_ALL_ONES;
        s2_nxt.mant = s1_r.mant;
      end else if (s1_r.cls.zero) begin
        s2_nxt.exp  = 8'd0;
        s2_nxt.mant = 10'd0;
      end else if (s1_r.cls.sub) begin
        s2_nxt.exp  = hsfc_pkg::SUB_EXP_BASE - {4'd0, lz};
        s2_nxt.mant = mant_sh;
      end else begin
        s2_nxt.exp  = s1_r.exp + hsfc_pkg::BIAS_DIFF;
        s2_nxt.mant = s1_r.mant;
      end
    end
  end

  // pack the output word
  always_comb begin
    if (s2_r.mode == hsfc_pkg::MODE_S2H) begin
      out_nxt = {16'd0, s2_r.sign, s2_r.exp[4:0], s2_r.mant};
    end else begin
      out_nxt = {s2_r.sign, s2_r.exp, s2_r.mant, 13'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      s1_r <= s1_nxt;
    end
    if (en2 && v1_r) begin
      s2_r <= s2_nxt;
    end
    if (en3 && v2_r) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== hdl/hsfc_chk.sv =====
module hsfc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_mode,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_value_out
);

  // empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set right after reset");

  // back pressure only when the output holds a word
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall raised while output is empty");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value_out))
    else $error("stalled output word changed");

  // an accepted word reaches out_valid when the receiver does not stall in between
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("accepted word not delivered after three cycles");

  // half results are zero extended
  a_half_upper: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_mode == hsfc_pkg::MODE_S2H) ##1 !out_stall
      ##1 !out_stall |=> out_value_out[31:16] == 16'd0)
    else $error("half result has upper bits set");

endmodule

bind half_single_float_converter hsfc_chk u_hsfc_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_mode       (in_mode),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_value_out (out_value_out)
);

// ===== dv/tb.sv =====
module tb;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_mode     = hsfc_pkg::MODE_S2H;
  logic [31:0] in_value_in = 32'h0;
  logic        out_stall   = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [31:0] out_value_out;

  half_single_float_converter DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_value_in   (in_value_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value_out (out_value_out)
  );

  typedef struct packed {
    logic        mode;
    logic [31:0] value;
    logic        fixed;
    logic [31:0] want;
  } conv_case_t;

  localparam int NUM_DIRECTED = 25;
  localparam int PHASE_WORDS  = 250;
  localparam int HOLD_CYCLES  = 40;

  // fixed rows carry a hand-computed result, the others use the predictor
  conv_case_t directed_cases [NUM_DIRECTED] = '{
    '{hsfc_pkg::MODE_S2H, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{hsfc_pkg::MODE_S2H, 32'h8000_0000, 1'b1, 32'h0000_8000},
    '{hsfc_pkg::MODE_S2H, 32'h7F80_0000, 1'b1, 32'h0000_7C00},
    '{hsfc_pkg::MODE_S2H, 32'hFF80_0000, 1'b1, 32'h0000_FC00},
    '{hsfc_pkg::MODE_S2H, 32'h7FC0_0000, 1'b1, 32'h0000_7E00},
    '{hsfc_pkg::MODE_S2H, 32'hFF80_0001, 1'b1, 32'h0000_FE00},
    '{hsfc_pkg::MODE_S2H, 32'h0000_0001, 1'b1, 32'h0000_0000},
    '{hsfc_pkg::MODE_S2H, 32'h807F_FFFF, 1'b1, 32'h0000_8000},
    '{hsfc_pkg::MODE_S2H, 32'h3800_0000, 1'b1, 32'h0000_0000},
    '{hsfc_pkg::MODE_S2H, 32'h3880_0000, 1'b1, 32'h0000_0400},
    '{hsfc_pkg::MODE_S2H, 32'h477F_E000, 1'b1, 32'h0000_7BFF},
    '{hsfc_pkg::MODE_S2H, 32'hC780_0000, 1'b1, 32'h0000_FC00},
    '{hsfc_pkg::MODE_S2H, 32'h3F80_1FFF, 1'b1, 32'h0000_3C00},
    '{hsfc_pkg::MODE_S2H, 32'h4049_0FDB, 1'b0, 32'h0000_0000},
    '{hsfc_pkg::MODE_H2S, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{hsfc_pkg::MODE_H2S, 32'h0000_8000, 1'b1, 32'h8000_0000},
    '{hsfc_pkg::MODE_H2S, 32'h0000_0001, 1'b1, 32'h3380_0000},
    '{hsfc_pkg::MODE_H2S, 32'h0000_83FF, 1'b1, 32'hB87F_C000},
    '{hsfc_pkg::MODE_H2S, 32'h0000_7C00, 1'b1, 32'h7F80_0000},
    '{hsfc_pkg::MODE_H2S, 32'h0000_FC00, 1'b1, 32'hFF80_0000},
    '{hsfc_pkg::MODE_H2S, 32'h0000_7E01, 1'b1, 32'h7FC0_2000},
    '{hsfc_pkg::MODE_H2S, 32'h0000_7BFF, 1'b1, 32'h477F_E000},
    '{hsfc_pkg::MODE_H2S, 32'hFFFF_3C00, 1'b1, 32'h3F80_0000},
    '{hsfc_pkg::MODE_H2S, 32'h0000_0400, 1'b1, 32'h3880_0000},
    '{hsfc_pkg::MODE_H2S, 32'hA5A5_B555, 1'b0, 32'h0000_0000}
  };

  logic [31:0] expected_words[$];
  int          mismatches     = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  bit          hold_request   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("[half_single_float_converter] ERROR");
    $finish;
  end

  function automatic logic [31:0] convert_word(logic mode, logic [31:0] value);
    logic        sgn;
    logic [7:0]  e8;
    logic [4:0]  e5;
    logic [22:0] m23;
    logic [10:0] m11;
    int          lz;
    if (mode == hsfc_pkg::MODE_S2H) begin
      sgn = value[31];
      e8  = value[30:23];
      m23 = value[22:0];
      if (e8 == hsfc_pkg::EXP8_ALL_ONES) return {16'h0, sgn, 5'h1F, m23 != 23'h0, 9'h0};
      if (e8 <= hsfc_pkg::BIAS_DIFF) return {16'h0, sgn, 15'h0};
      if (e8 >= hsfc_pkg::S2H_OVF_EXP) return {16'h0, sgn, 5'h1F, 10'h0};
      e8 = e8 - hsfc_pkg::BIAS_DIFF;
      return {16'h0, sgn, e8[4:0], m23[22:13]};
    end
    sgn = value[15];
    e5  = value[14:10];
    m11 = {1'b0, value[9:0]};
    if (e5 == 5'h0) begin
      if (m11 == 11'h0) return {sgn, 31'h0};
      lz = 0;
      while (!m11[10]) begin
        m11 = m11 << 1;
        lz++;
      end
      return {sgn, 8'(113 - lz), m11[9:0], 13'h0};
    end
    if (e5 == hsfc_pkg::EXP5_ALL_ONES) return {sgn, 8'hFF, value[9:0], 13'h0};
    return {sgn, 8'(e5 + 112), value[9:0], 13'h0};
  endfunction

  // bias exponents toward zero, all ones and the flush/saturate boundaries
  function automatic void pick_operand(output logic mode, output logic [31:0] value);
    mode  = 1'($urandom_range(1));
    value = $urandom;
    case ($urandom_range(7))
      0: value[30:23] = 8'h00;
      1: value[30:23] = 8'hFF;
      2: value[30:23] = 8'($urandom_range(100, 150));
      3: value[14:10] = 5'h00;
      4: value[14:10] = 5'h1F;
      default: ;
    endcase
  endfunction

  task automatic send_word(input logic mode, input logic [31:0] value, input logic [31:0] want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_value_in <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_words.push_back(want);
  endtask

  task automatic drain_queue();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic        mode;
    logic [31:0] value;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 22;
    recv_stall_pct = 88;
    foreach (directed_cases[i]) begin
      send_word(directed_cases[i].mode, directed_cases[i].value,
                directed_cases[i].fixed ? directed_cases[i].want :
                convert_word(directed_cases[i].mode, directed_cases[i].value));
    end

    for (int phase = 0; phase < 3; phase++) begin
      if (phase != 0) drain_queue();
      send_idle_pct  = (phase == 0) ? 22 : (phase == 1) ? 88 : 0;
      recv_stall_pct = (phase == 0) ? 88 : (phase == 1) ? 22 : 0;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (phase == 2 && i == 60) hold_request = 1'b1;
        pick_operand(mode, value);
        send_word(mode, value, convert_word(mode, value));
      end
    end

    drain_queue();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[half_single_float_converter] OK");
    end else begin
      $display("[half_single_float_converter] ERROR");
    end
    $finish;
  end

  initial begin
    int          hold_left;
    logic [31:0] want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, out_value_out);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (out_value_out !== want) begin
            $display("%0t: value_out mismatch, expected %h, actual %h",
                     $time, want, out_value_out);
            mismatches++;
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

endmodule
